/* design/vtxd_pkg.sv */
package vtxd_pkg;

    // Frame limits and framing constants.
    localparam int MAX_FRAME_LEN = 32;
    localparam int LEN_LIMIT     = MAX_FRAME_LEN - 2;
    localparam int HEAD_DEPTH    = 5;
    localparam int EVQ_DEPTH     = 4;

    localparam logic [7:0]  CRC_POLY    = 8'hD5;
    localparam logic [7:0]  PRE1_BYTE   = 8'hAA;
    localparam logic [7:0]  PRE2_BYTE   = 8'h55;
    localparam logic [7:0]  CODE_GET_V1 = 8'h01;
    localparam logic [7:0]  CODE_GET_V2 = 8'h09;
    localparam logic [7:0]  CODE_SET_FREQ = 8'h04;
    localparam logic [15:0] PIT_GET_BIT = 16'h4000;

    // Parser states.
    typedef enum logic [2:0] {
        ST_PRE1 = 3'd0,
        ST_PRE2 = 3'd1,
        ST_CODE = 3'd2,
        ST_LEN  = 3'd3,
        ST_DATA = 3'd4,
        ST_CRC  = 3'd5
    } parse_state_t;

    // Result status codes.
    typedef enum logic [2:0] {
        STAT_NONE    = 3'd0,
        STAT_GOOD    = 3'd1,
        STAT_BAD_PRE = 3'd2,
        STAT_BAD_LEN = 3'd3,
        STAT_CRC_ERR = 3'd4,
        STAT_ECHO    = 3'd5
    } status_t;

    // One classified item handed from the parser to the state update.
    typedef struct packed {
        logic                              is_cmd;
        logic [6:0]                        cmd;
        logic                              pit_query;
        status_t                           status;
        logic [7:0]                        code;
        logic [7:0]                        len;
        logic [HEAD_DEPTH-1:0][7:0]        head;
    } vtxd_evt_t;

    // Bitwise CRC-8 update over one byte, most significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] v;
        v = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            if (v[7]) begin
                v = {v[6:0], 1'b0} ^ CRC_POLY;
            end
            else begin
                v = {v[6:0], 1'b0};
            end
        end
        return v;
    endfunction

endpackage

/* design/vtx_response_deframer.sv */
// An accepted item is first written into the event queue and then, once the result slot
// is free or being popped, into the result registers of the back end.
// Throughput: one item per cycle while the event queue is not full; the byte parser and
// the device state update are joined by a four-entry event queue that absorbs result stalls.
// Reset: rst_n is asynchronous; the parser waits for the first preamble byte, device channel,
// power and mode read as -1, version and frequencies as zero, and all error counters are zero.
module vtx_response_deframer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  logic               kind,
    input  logic [7:0]         data_byte,
    input  logic [6:0]         sent_cmd,
    input  logic               pit_query,
    output logic               empty,
    input  logic               pop,
    output logic [2:0]         frame_status,
    output logic [7:0]         awaiting_cmd,
    output logic [1:0]         dev_version,
    output logic signed [7:0]  dev_channel,
    output logic signed [7:0]  dev_power,
    output logic signed [7:0]  dev_opmode,
    output logic [15:0]        dev_freq,
    output logic [15:0]        pit_frequency,
    output logic [15:0]        count_bad_preamble,
    output logic [15:0]        count_bad_length,
    output logic [15:0]        count_crc_error,
    output logic [15:0]        count_out_of_order
);
    import vtxd_pkg::*;

    vtxd_evt_t front_evt, q_evt;
    logic      in_take, q_valid, q_take;

    assign in_take = push && !full;

    // Front end: byte parser and item classification.
    vtxd_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (in_take),
        .kind      (kind),
        .data_byte (data_byte),
        .sent_cmd  (sent_cmd),
        .pit_query (pit_query),
        .evt       (front_evt)
    );

    // Queue between parser and state update.
    vtxd_evq u_evq (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (in_take),
        .wr_data   (front_evt),
        .rd_en     (q_take),
        .full      (full),
        .not_empty (q_valid),
        .rd_data   (q_evt)
    );

    // Back end: device state, counters and result slot.
    vtxd_back u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .evt_valid          (q_valid),
        .evt                (q_evt),
        .evt_take           (q_take),
        .pop                (pop),
        .empty              (empty),
        .frame_status       (frame_status),
        .awaiting_cmd       (awaiting_cmd),
        .dev_version        (dev_version),
        .dev_channel        (dev_channel),
        .dev_power          (dev_power),
        .dev_opmode         (dev_opmode),
        .dev_freq           (dev_freq),
        .pit_frequency      (pit_frequency),
        .count_bad_preamble (count_bad_preamble),
        .count_bad_length   (count_bad_length),
        .count_crc_error    (count_crc_error),
        .count_out_of_order (count_out_of_order)
    );

endmodule

/* design/vtxd_front.sv */
module vtxd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic               kind,
    input  logic [7:0]         data_byte,
    input  logic [6:0]         sent_cmd,
    input  logic               pit_query,
    output vtxd_pkg::vtxd_evt_t evt
);
    import vtxd_pkg::*;

    localparam int CNT_IDX_W = $clog2(HEAD_DEPTH);

    parse_state_t state_reg, state_next;
    logic [7:0] code_reg, code_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] cnt_reg, cnt_next;
    logic [7:0] crc_reg, crc_next;
    logic [HEAD_DEPTH-1:0][7:0] head_reg, head_next;
    logic       head_we;
    status_t    status;
    logic [7:0] cnt_inc;
    logic       byte_take;

    assign byte_take = take && !kind;
    assign cnt_inc   = cnt_reg + 8'd1;

    // Next parser state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_PRE2:
            begin
                state_next = (data_byte == PRE2_BYTE) ? ST_CODE : ST_PRE1;
            end
            ST_CODE:
            begin
                state_next = ST_LEN;
            end
            ST_LEN:
            begin
                if ({1'b0, data_byte} > 9'(LEN_LIMIT)) begin
                    state_next = ST_PRE1;
                end
                else if (data_byte == 8'd0) begin
                    state_next = ST_CRC;
                end
                else begin
                    state_next = ST_DATA;
                end
            end
            ST_DATA:
            begin
                if (cnt_inc == len_reg) begin
                    state_next = ST_CRC;
                end
            end
            ST_CRC:
            begin
                state_next = ST_PRE1;
            end
            default:
            begin
                state_next = (data_byte == PRE1_BYTE) ? ST_PRE2 : ST_PRE1;
            end
        endcase
    end

    // Datapath updates and status for the current byte.
    always_comb
    begin
        code_next = code_reg;
        len_next  = len_reg;
        cnt_next  = cnt_reg;
        crc_next  = crc_reg;
        head_next = head_reg;
        head_we   = 1'b0;
        status    = STAT_NONE;
        unique case (state_reg)
            ST_PRE2:
            begin
                if (data_byte != PRE2_BYTE) begin
                    status = STAT_BAD_PRE;
                end
            end
            ST_CODE:
            begin
                code_next = data_byte;
                crc_next  = crc8_update(8'd0, data_byte);
            end
            ST_LEN:
            begin
                len_next = data_byte;
                crc_next = crc8_update(crc_reg, data_byte);
                cnt_next = 8'd0;
                if ({1'b0, data_byte} > 9'(LEN_LIMIT)) begin
                    status = STAT_BAD_LEN;
                end
            end
            ST_DATA:
            begin
                if (cnt_reg < 8'(HEAD_DEPTH)) begin
                    head_next[cnt_reg[CNT_IDX_W-1:0]] = data_byte;
                    head_we = 1'b1;
                end
                crc_next = crc8_update(crc_reg, data_byte);
                cnt_next = cnt_inc;
            end
            ST_CRC:
            begin
                if (crc_reg == data_byte) begin
                    status = STAT_GOOD;
                end
                else if (code_reg[0]) begin
                    status = STAT_ECHO;
                end
                else begin
                    status = STAT_CRC_ERR;
                end
            end
            default:
            begin
                status = STAT_NONE;
            end
        endcase
    end

    // Parser control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= ST_PRE1;
            code_reg  <= 8'd0;
            len_reg   <= 8'd0;
            cnt_reg   <= 8'd0;
            crc_reg   <= 8'd0;
        end
        else if (byte_take) begin
            state_reg <= state_next;
            code_reg  <= code_next;
            len_reg   <= len_next;
            cnt_reg   <= cnt_next;
            crc_reg   <= crc_next;
        end
    end

    // Payload head bytes hold no reset value.
    always_ff @(posedge clk)
    begin
        if (byte_take && head_we) begin
            head_reg <= head_next;
        end
    end

    // Classified item for the back end.
    always_comb
    begin
        evt.is_cmd    = kind;
        evt.cmd       = sent_cmd;
        evt.pit_query = pit_query;
        evt.status    = kind ? STAT_NONE : status;
        evt.code      = code_reg;
        evt.len       = len_reg;
        evt.head      = head_reg;
    end

endmodule

/* design/vtxd_evq.sv */
module vtxd_evq (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  vtxd_pkg::vtxd_evt_t wr_data,
    input  logic                rd_en,
    output logic                full,
    output logic                not_empty,
    output vtxd_pkg::vtxd_evt_t rd_data
);
    import vtxd_pkg::*;

    localparam int PTR_W = $clog2(EVQ_DEPTH);
    localparam int CNT_W = $clog2(EVQ_DEPTH + 1);

    vtxd_evt_t mem_reg [EVQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic do_wr, do_rd;

    assign full      = (count_reg == CNT_W'(EVQ_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_wr     = wr_en && !full;
    assign do_rd     = rd_en && not_empty;
    assign rd_data   = mem_reg[rd_ptr_reg];

    // Occupancy follows the write and read strobes.
    always_comb
    begin
        count_next = count_reg;
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(EVQ_DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(EVQ_DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    // Item storage.
    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // The count never exceeds the depth.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(EVQ_DEPTH))
        else $error("event queue count over depth");

    // A write without a read raises the count by one.
    a_count_inc: assert property (@(posedge clk) disable iff (!rst_n)
        (do_wr && !do_rd) |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("event queue count did not advance");

endmodule

/* design/vtxd_back.sv */
module vtxd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                evt_valid,
    input  vtxd_pkg::vtxd_evt_t evt,
    output logic                evt_take,
    input  logic                pop,
    output logic                empty,
    output logic [2:0]          frame_status,
    output logic [7:0]          awaiting_cmd,
    output logic [1:0]          dev_version,
    output logic signed [7:0]   dev_channel,
    output logic signed [7:0]   dev_power,
    output logic signed [7:0]   dev_opmode,
    output logic [15:0]         dev_freq,
    output logic [15:0]         pit_frequency,
    output logic [15:0]         count_bad_preamble,
    output logic [15:0]         count_bad_length,
    output logic [15:0]         count_crc_error,
    output logic [15:0]         count_out_of_order
);
    import vtxd_pkg::*;

    logic       out_valid_reg;
    status_t    status_reg;
    logic [7:0] await_reg, await_next;
    logic       pit_pend_reg, pit_pend_next;
    logic [1:0] ver_reg, ver_next;
    logic [7:0] chan_reg, chan_next;
    logic [7:0] pwr_reg, pwr_next;
    logic [7:0] mode_reg, mode_next;
    logic [15:0] freq_reg, freq_next;
    logic [15:0] pit_freq_reg, pit_freq_next;
    logic [15:0] cnt_pre_reg, cnt_len_reg, cnt_crc_reg, cnt_ooo_reg;
    logic [15:0] cnt_pre_next, cnt_len_next, cnt_crc_next, cnt_ooo_next;
    logic        is_good;

    // Take a new item whenever the result slot is free or being drained.
    assign evt_take = evt_valid && (!out_valid_reg || pop);
    assign is_good  = !evt.is_cmd && (evt.status == STAT_GOOD);

    // Device state update for one item.
    always_comb
    begin
        await_next    = await_reg;
        pit_pend_next = pit_pend_reg;
        ver_next      = ver_reg;
        chan_next     = chan_reg;
        pwr_next      = pwr_reg;
        mode_next     = mode_reg;
        freq_next     = freq_reg;
        pit_freq_next = pit_freq_reg;
        cnt_pre_next  = cnt_pre_reg;
        cnt_len_next  = cnt_len_reg;
        cnt_crc_next  = cnt_crc_reg;
        cnt_ooo_next  = cnt_ooo_reg;
        if (evt.is_cmd) begin
            await_next    = {1'b0, evt.cmd};
            pit_pend_next = pit_pend_reg | evt.pit_query;
        end
        else begin
            if (evt.status == STAT_BAD_PRE) begin
                cnt_pre_next = cnt_pre_reg + 16'd1;
            end
            if (evt.status == STAT_BAD_LEN) begin
                cnt_len_next = cnt_len_reg + 16'd1;
            end
            if (evt.status == STAT_CRC_ERR) begin
                cnt_crc_next = cnt_crc_reg + 16'd1;
            end
        end
        if (is_good) begin
            // A settings reply answers a plain settings query as well.
            priority if (evt.code == await_reg) begin
                await_next = 8'd0;
            end
            else if (evt.code == CODE_GET_V2 && await_reg == CODE_GET_V1) begin
                await_next = 8'd0;
            end
            else begin
                cnt_ooo_next = cnt_ooo_reg + 16'd1;
            end
            // Decode settings or pit frequency replies.
            if (evt.code == CODE_GET_V1 || evt.code == CODE_GET_V2) begin
                if (evt.len >= 8'd5) begin
                    ver_next  = (evt.code == CODE_GET_V1) ? 2'd1 : 2'd2;
                    chan_next = evt.head[0];
                    pwr_next  = evt.head[1];
                    mode_next = evt.head[2];
                    freq_next = {evt.head[3], evt.head[4]};
                end
            end
            else if (evt.code == CODE_SET_FREQ) begin
                if (evt.len >= 8'd3 && pit_pend_reg) begin
                    pit_freq_next = {evt.head[0], evt.head[1]} & ~PIT_GET_BIT;
                end
            end
        end
    end

    // State registers double as the result fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
            status_reg    <= STAT_NONE;
            await_reg     <= 8'd0;
            pit_pend_reg  <= 1'b0;
            ver_reg       <= 2'd0;
            chan_reg      <= 8'hFF;
            pwr_reg       <= 8'hFF;
            mode_reg      <= 8'hFF;
            freq_reg      <= 16'd0;
            pit_freq_reg  <= 16'd0;
            cnt_pre_reg   <= 16'd0;
            cnt_len_reg   <= 16'd0;
            cnt_crc_reg   <= 16'd0;
            cnt_ooo_reg   <= 16'd0;
        end
        else begin
            if (evt_take) begin
                out_valid_reg <= 1'b1;
                status_reg    <= evt.status;
                await_reg     <= await_next;
                pit_pend_reg  <= pit_pend_next;
                ver_reg       <= ver_next;
                chan_reg      <= chan_next;
                pwr_reg       <= pwr_next;
                mode_reg      <= mode_next;
                freq_reg      <= freq_next;
                pit_freq_reg  <= pit_freq_next;
                cnt_pre_reg   <= cnt_pre_next;
                cnt_len_reg   <= cnt_len_next;
                cnt_crc_reg   <= cnt_crc_next;
                cnt_ooo_reg   <= cnt_ooo_next;
            end
            else if (pop) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign empty              = !out_valid_reg;
    assign frame_status       = status_reg;
    assign awaiting_cmd       = await_reg;
    assign dev_version        = ver_reg;
    assign dev_channel        = chan_reg;
    assign dev_power          = pwr_reg;
    assign dev_opmode         = mode_reg;
    assign dev_freq           = freq_reg;
    assign pit_frequency      = pit_freq_reg;
    assign count_bad_preamble = cnt_pre_reg;
    assign count_bad_length   = cnt_len_reg;
    assign count_crc_error    = cnt_crc_reg;
    assign count_out_of_order = cnt_ooo_reg;

    // The awaited code is only ever a seven-bit command or zero.
    a_await_msb: assert property (@(posedge clk) disable iff (!rst_n)
        !await_reg[7])
        else $error("awaited command has bit 7 set");

    // A waiting result that is not popped keeps its device state.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pop) |=> ($stable(await_reg) && $stable(cnt_ooo_reg)))
        else $error("waiting result changed");

    // The out-of-order counter moves only on a good frame.
    a_ooo_good: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_ooo_reg != $past(cnt_ooo_reg)) |-> (status_reg == STAT_GOOD))
        else $error("out-of-order count moved without a good frame");

endmodule
